// File: rtl/nmea_gga_position_extractor_core_macros.svh
`ifndef NMEA_GGA_POSITION_EXTRACTOR_CORE_MACROS_SVH
`define NMEA_GGA_POSITION_EXTRACTOR_CORE_MACROS_SVH

// check cons on the cycle of ante
`define NGGA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ngga check failed");

// check cons on the cycle after ante
`define NGGA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ngga check failed");

`endif

// File: rtl/ngga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ngga_pkg;

  localparam int MaxHeightCharsDef = 9;

  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChDollar = 8'h24;

  localparam logic [3:0] LatLen = 4'd9;
  localparam logic [3:0] LonLen = 4'd10;

  localparam logic [6:0] NsPos     = 7'd23;
  localparam logic [6:0] EwPos     = 7'd50;
  localparam logic [6:0] HeightPos = 7'd63;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoHeader  = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic       write_valid;
    logic [6:0] line_position;
    logic [7:0] line_char;
    logic       frame_done;
    logic [1:0] parse_status;
  } out_item_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] lat_pos(input logic [3:0] cnt);
    logic [6:0] p;
    if (cnt < 4'd2) begin
      p = 7'd13 + {3'd0, cnt};
    end else begin
      p = 7'd14 + {3'd0, cnt};
    end
    return p;
  endfunction

  function automatic logic [6:0] lon_pos(input logic [3:0] cnt);
    logic [6:0] p;
    if (cnt < 4'd3) begin
      p = 7'd39 + {3'd0, cnt};
    end else begin
      p = 7'd40 + {3'd0, cnt};
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ngga_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module ngga_parse #(
  parameter int MaxHeightChars = ngga_pkg::MaxHeightCharsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire ngga_pkg::in_item_t  item_i,
  output logic                     emit_o,
  output ngga_pkg::out_item_t      result_o
);
  import ngga_pkg::*;

  localparam logic [3:0] PhSearch   = 4'd0;
  localparam logic [3:0] PhSkipHdr  = 4'd1;
  localparam logic [3:0] PhSkipTime = 4'd2;
  localparam logic [3:0] PhLat      = 4'd3;
  localparam logic [3:0] PhLatSkip  = 4'd4;
  localparam logic [3:0] PhNs       = 4'd5;
  localparam logic [3:0] PhNsSkip   = 4'd6;
  localparam logic [3:0] PhLon      = 4'd7;
  localparam logic [3:0] PhLonSkip  = 4'd8;
  localparam logic [3:0] PhEw       = 4'd9;
  localparam logic [3:0] PhEwSkip   = 4'd10;
  localparam logic [3:0] PhSkipFix  = 4'd11;
  localparam logic [3:0] PhSkipSats = 4'd12;
  localparam logic [3:0] PhSkipHdop = 4'd13;
  localparam logic [3:0] PhHeight   = 4'd14;
  localparam logic [3:0] PhDone     = 4'd15;

  localparam logic [4:0] HeightMax = 5'(MaxHeightChars);

  logic [3:0] phase_q, phase_d;
  logic [2:0] hdr_q, hdr_d;
  logic [3:0] cnt_q, cnt_d;
  logic       found_q, found_d;
  logic       height_q, height_d;

  logic [7:0] b;
  logic       is_comma;
  logic [4:0] cnt_inc;
  logic       wr;
  logic [6:0] pos;
  logic [1:0] status;

  assign b        = item_i.rx_byte;
  assign is_comma = (b == ChComma);
  assign cnt_inc  = {1'b0, cnt_q} + 5'd1;

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    height_d = height_q;
    wr       = 1'b0;
    pos      = 7'd0;
    case (phase_q)
      PhSearch: begin
        if (hdr_q < 3'd6 && b == hdr_char(hdr_q)) begin
          if (hdr_q == 3'd5) begin
            found_d = 1'b1;
            hdr_d   = 3'd0;
            phase_d = PhSkipHdr;
          end else begin
            hdr_d = hdr_q + 3'd1;
          end
        end else begin
          hdr_d = (b == ChDollar) ? 3'd1 : 3'd0;
        end
      end
      PhSkipHdr: begin
        if (is_comma) phase_d = PhSkipTime;
      end
      PhSkipTime: begin
        if (is_comma) begin
          phase_d = PhLat;
          cnt_d   = 4'd0;
        end
      end
      PhLat: begin
        if (cnt_q == 4'd0 && is_comma) begin
          phase_d = PhNs;
        end else begin
          wr  = 1'b1;
          pos = lat_pos(cnt_q);
          if (cnt_inc >= {1'b0, LatLen}) begin
            cnt_d   = 4'd0;
            phase_d = PhLatSkip;
          end else begin
            cnt_d = cnt_inc[3:0];
          end
        end
      end
      PhLatSkip: phase_d = PhNs;
      PhNs: begin
        if (!is_comma) begin
          wr  = 1'b1;
          pos = NsPos;
        end
        phase_d = PhNsSkip;
      end
      PhNsSkip: begin
        phase_d = PhLon;
        cnt_d   = 4'd0;
      end
      PhLon: begin
        if (cnt_q == 4'd0 && is_comma) begin
          phase_d = PhEw;
        end else begin
          wr  = 1'b1;
          pos = lon_pos(cnt_q);
          if (cnt_inc >= {1'b0, LonLen}) begin
            cnt_d   = 4'd0;
            phase_d = PhLonSkip;
          end else begin
            cnt_d = cnt_inc[3:0];
          end
        end
      end
      PhLonSkip: phase_d = PhEw;
      PhEw: begin
        if (!is_comma) begin
          wr      = 1'b1;
          pos     = EwPos;
          phase_d = PhEwSkip;
        end else begin
          phase_d = PhSkipFix;
        end
      end
      PhEwSkip: phase_d = PhSkipFix;
      PhSkipFix: begin
        if (is_comma) phase_d = PhSkipSats;
      end
      PhSkipSats: begin
        if (is_comma) phase_d = PhSkipHdop;
      end
      PhSkipHdop: begin
        if (is_comma) begin
          phase_d = PhHeight;
          cnt_d   = 4'd0;
        end
      end
      PhHeight: begin
        height_d = 1'b1;
        if (is_comma) begin
          phase_d = PhDone;
        end else begin
          wr    = 1'b1;
          pos   = HeightPos + {3'd0, cnt_q};
          cnt_d = cnt_inc[3:0];
          if (cnt_inc >= HeightMax) phase_d = PhDone;
        end
      end
      default: ;
    endcase

    if (!found_d) begin
      status = StatusNoHeader;
    end else if (!height_d) begin
      status = StatusTruncated;
    end else begin
      status = StatusOk;
    end
  end

  assign emit_o                 = wr || item_i.frame_end;
  assign result_o.write_valid   = wr;
  assign result_o.line_position = wr ? pos : 7'd0;
  assign result_o.line_char     = wr ? b : 8'd0;
  assign result_o.frame_done    = item_i.frame_end;
  assign result_o.parse_status  = item_i.frame_end ? status : StatusOk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSearch;
      hdr_q    <= 3'd0;
      cnt_q    <= 4'd0;
      found_q  <= 1'b0;
      height_q <= 1'b0;
    end else if (accept_i) begin
      if (item_i.frame_end) begin
        phase_q  <= PhSearch;
        hdr_q    <= 3'd0;
        cnt_q    <= 4'd0;
        found_q  <= 1'b0;
        height_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        hdr_q    <= hdr_d;
        cnt_q    <= cnt_d;
        found_q  <= found_d;
        height_q <= height_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ngga_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ngga_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire ngga_pkg::out_item_t  item_i,
  output logic                      full_o,
  input  wire logic                 out_stall_i,
  output ngga_pkg::out_item_t       item_o
);
  import ngga_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign full_o = valid_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

// File: rtl/nmea_gga_position_extractor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o    in_item_i  (rx_byte, frame_end)
// out       source     out_valid_o / out_stall_i  out_item_o (write, position, char, done, status)
//
// One byte per cycle unless stalled; a result shows the cycle after its byte is taken.
// The parser state updates in the same cycle the byte is taken; the result register
// is the only stage, so in_stall_o is high only while a held result is stalled.
// Bytes that produce no write and do not end the frame yield no result.
// Reset clears the parser to header search and empties the result register.

module nmea_gga_position_extractor_core #(
  parameter int MaxHeightChars = ngga_pkg::MaxHeightCharsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ngga_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ngga_pkg::out_item_t       out_item_o
);
  import ngga_pkg::*;

  logic      accept;
  logic      emit;
  logic      full;
  out_item_t result;

  assign in_stall_o  = full && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = full;

  ngga_parse #(
    .MaxHeightChars(MaxHeightChars)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .emit_o  (emit),
    .result_o(result)
  );

  ngga_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && emit),
    .item_i     (result),
    .full_o     (full),
    .out_stall_i(out_stall_i),
    .item_o     (out_item_o)
  );

`include "nmea_gga_position_extractor_core_macros.svh"

  `NGGA_ASSERT_NOW(a_no_empty_result, out_valid_o && !out_item_o.frame_done, out_item_o.write_valid)
  `NGGA_ASSERT_NOW(a_status_only_at_end, out_valid_o && !out_item_o.frame_done, out_item_o.parse_status == StatusOk)
  `NGGA_ASSERT_NEXT(a_frame_end_reported, accept && in_item_i.frame_end, out_valid_o && out_item_o.frame_done)
  `NGGA_ASSERT_NOW(a_empty_never_stalls, !out_valid_o, !in_stall_o)

endmodule

`default_nettype wire
